// ----- src/prc_pkg.sv -----
// Shared types and constants for the priority rule packet classifier.
`default_nettype none
package prc_pkg;

	localparam int unsigned DEF_RULE_SLOTS      = 64;
	localparam int unsigned DEF_PRIORITY_LEVELS = 10;
	localparam int unsigned ID_W                = 16;
	localparam int unsigned IP_W                = 32;
	localparam int unsigned LEN_W               = 6;
	localparam int unsigned PORT_W              = 16;
	localparam int unsigned PRIO_W              = 4;

	typedef enum logic [1:0] {
		OP_CLASSIFY = 2'd0,
		OP_ADD_PASS = 2'd1,
		OP_ADD_BLOCK = 2'd2,
		OP_DEACT    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_PRIO  = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		SM_CLASSIFY = 2'd0,
		SM_FIND     = 2'd1,
		SM_CLEAR    = 2'd2
	} scan_mode_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [1:0]        protocol;
		logic [IP_W-1:0]   src_ip;
		logic [LEN_W-1:0]  src_len;
		logic [IP_W-1:0]   dst_ip;
		logic [LEN_W-1:0]  dst_len;
		logic [PORT_W-1:0] src_lo;
		logic [PORT_W-1:0] src_hi;
		logic [PORT_W-1:0] dst_lo;
		logic [PORT_W-1:0] dst_hi;
		logic [PRIO_W-1:0] prio;
		logic              action;
	} rule_t;

	typedef struct packed {
		logic       accept;
		logic       add_commit;
		logic       scan_start;
		scan_mode_t scan_mode;
		logic       result_load;
	} prc_cmd_t;

	typedef struct packed {
		opcode_t op;
		logic    scan_busy;
		logic    found;
		logic    out_full;
	} prc_stat_t;

	// Saturate a prefix length to the address width.
	function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
		sat_len = (len > LEN_W'(IP_W)) ? LEN_W'(IP_W) : len;
	endfunction

	function automatic logic prefix_hit(input logic [IP_W-1:0] pfx,
			input logic [LEN_W-1:0] len, input logic [IP_W-1:0] addr);
		logic [IP_W-1:0] mask;
		mask = ~({IP_W{1'b1}} >> len);
		prefix_hit = ((addr ^ pfx) & mask) == '0;
	endfunction

endpackage
`default_nettype wire

// ----- src/prc_ram.sv -----
// Generic single write, single read RAM with registered read data.
`default_nettype none
module prc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- src/prc_ctrl.sv -----
// Sequencer for accept, add, classify scan and two-pass deactivate.
`default_nettype none
module prc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire prc_pkg::prc_stat_t st,
	output prc_pkg::prc_cmd_t      cmd
);
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_EXEC  = 6'b000010,
		S_CSCAN = 6'b000100,
		S_DFIND = 6'b001000,
		S_DCLR  = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.scan_mode = prc_pkg::SM_CLASSIFY;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (st.op)
					prc_pkg::OP_CLASSIFY: begin
						cmd.scan_start = 1'b1;
						state_d = S_CSCAN;
					end
					prc_pkg::OP_DEACT: begin
						cmd.scan_start = 1'b1;
						cmd.scan_mode = prc_pkg::SM_FIND;
						state_d = S_DFIND;
					end
					default: begin
						cmd.add_commit = 1'b1;
						state_d = S_DONE;
					end
				endcase
			end
			S_CSCAN: begin
				if (!st.scan_busy)
					state_d = S_DONE;
			end
			S_DFIND: begin
				if (!st.scan_busy) begin
					if (st.found) begin
						cmd.scan_start = 1'b1;
						cmd.scan_mode = prc_pkg::SM_CLEAR;
						state_d = S_DCLR;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_DCLR: begin
				if (!st.scan_busy)
					state_d = S_DONE;
			end
			S_DONE: begin
				// hold until the output register is free
				if (!st.out_full) begin
					cmd.result_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end
endmodule
`default_nettype wire

// ----- src/prc_dp.sv -----
// Rule storage, scan pipeline, best-match selection and result register.
`default_nettype none
module prc_dp #(
	parameter int unsigned RULE_SLOTS      = prc_pkg::DEF_RULE_SLOTS,
	parameter int unsigned PRIORITY_LEVELS = prc_pkg::DEF_PRIORITY_LEVELS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire prc_pkg::prc_cmd_t            cmd,
	output prc_pkg::prc_stat_t                st,
	input  wire logic [1:0]                   opcode,
	input  wire logic [1:0]                   protocol,
	input  wire logic [prc_pkg::IP_W-1:0]     src_ip,
	input  wire logic [prc_pkg::LEN_W-1:0]    src_prefix_len,
	input  wire logic [prc_pkg::IP_W-1:0]     dst_ip,
	input  wire logic [prc_pkg::LEN_W-1:0]    dst_prefix_len,
	input  wire logic [prc_pkg::PORT_W-1:0]   src_port_low,
	input  wire logic [prc_pkg::PORT_W-1:0]   src_port_high,
	input  wire logic [prc_pkg::PORT_W-1:0]   dst_port_low,
	input  wire logic [prc_pkg::PORT_W-1:0]   dst_port_high,
	input  wire logic [prc_pkg::PRIO_W-1:0]   priority_req,
	input  wire logic [prc_pkg::ID_W-1:0]     target_rule_id,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              verdict,
	output logic                              hit,
	output logic [1:0]                        status,
	output logic [prc_pkg::ID_W-1:0]          rule_id
);
	localparam int unsigned AW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
	localparam int unsigned CW = $clog2(RULE_SLOTS + 1);
	localparam int unsigned RW = $bits(prc_pkg::rule_t);
	localparam int unsigned PW = prc_pkg::PRIO_W;

	// latched item
	prc_pkg::opcode_t               op_q;
	logic [1:0]                     proto_q;
	logic [prc_pkg::IP_W-1:0]       sip_q, dip_q;
	logic [prc_pkg::LEN_W-1:0]      slen_q, dlen_q;
	logic [prc_pkg::PORT_W-1:0]     splo_q, sphi_q, dplo_q, dphi_q;
	logic [PW-1:0]                  prio_q;
	logic [prc_pkg::ID_W-1:0]       target_q;

	logic [CW-1:0]                  fill_q;
	logic [prc_pkg::ID_W-1:0]       next_id_q;
	logic [prc_pkg::ID_W-1:0]       add_id_q;
	prc_pkg::status_t               add_st_q;

	prc_pkg::scan_mode_t            mode_q;
	logic                           scan_on_q;
	logic [CW-1:0]                  idx_q;
	logic                           v_s1;
	logic [AW-1:0]                  idx_s1;
	logic                           v_s2, match_s2, idhit_s2, act_s2;
	logic [PW-1:0]                  prio_s2;
	logic [prc_pkg::ID_W-1:0]       id_s2;
	logic [AW-1:0]                  idx_s2;

	logic                           best_v_q, best_act_q;
	logic [PW-1:0]                  best_p_q;
	logic [prc_pkg::ID_W-1:0]       best_id_q;
	logic                           found_q;
	logic [PW-1:0]                  low_p_q;

	prc_pkg::rule_t                 new_rule, rd_rule;
	logic [RW-1:0]                  rd_word;
	logic                           rd_active;
	logic                           add_ok, prio_bad;
	logic                           act_we, act_wd;
	logic [AW-1:0]                  act_wa;
	logic                           m_proto, m_src, m_dst, m_sp, m_dp;

	assign prio_bad = {1'b0, prio_q} >= (PW+1)'(PRIORITY_LEVELS);
	assign add_ok   = cmd.add_commit && !prio_bad && (fill_q != CW'(RULE_SLOTS));

	always_comb begin
		new_rule.id       = next_id_q;
		new_rule.protocol = proto_q;
		new_rule.src_ip   = sip_q;
		new_rule.src_len  = prc_pkg::sat_len(slen_q);
		new_rule.dst_ip   = dip_q;
		new_rule.dst_len  = prc_pkg::sat_len(dlen_q);
		new_rule.src_lo   = splo_q;
		new_rule.src_hi   = sphi_q;
		new_rule.dst_lo   = dplo_q;
		new_rule.dst_hi   = dphi_q;
		new_rule.prio     = prio_q;
		new_rule.action   = (op_q == prc_pkg::OP_ADD_PASS);
	end

	prc_ram #(.WIDTH(RW), .DEPTH(RULE_SLOTS)) u_rule_ram (
		.clk   (clk),
		.we    (add_ok),
		.waddr (fill_q[AW-1:0]),
		.wdata (new_rule),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_word)
	);

	// clear pass writes at the stage-two slot
	assign act_we = add_ok || (v_s2 && mode_q == prc_pkg::SM_CLEAR && idhit_s2 &&
		prio_s2 == low_p_q);
	assign act_wa = add_ok ? fill_q[AW-1:0] : idx_s2;
	assign act_wd = add_ok;

	prc_ram #(.WIDTH(1), .DEPTH(RULE_SLOTS)) u_act_ram (
		.clk   (clk),
		.we    (act_we),
		.waddr (act_wa),
		.wdata (act_wd),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_active)
	);

	assign rd_rule = prc_pkg::rule_t'(rd_word);
	assign m_proto = (rd_rule.protocol == 2'd0) || (rd_rule.protocol == proto_q);
	assign m_src   = prc_pkg::prefix_hit(rd_rule.src_ip, rd_rule.src_len, sip_q);
	assign m_dst   = prc_pkg::prefix_hit(rd_rule.dst_ip, rd_rule.dst_len, dip_q);
	assign m_sp    = (splo_q >= rd_rule.src_lo) && (splo_q <= rd_rule.src_hi);
	assign m_dp    = (dplo_q >= rd_rule.dst_lo) && (dplo_q <= rd_rule.dst_hi);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q     <= prc_pkg::opcode_t'(opcode);
			proto_q  <= protocol;
			sip_q    <= src_ip;
			slen_q   <= src_prefix_len;
			dip_q    <= dst_ip;
			dlen_q   <= dst_prefix_len;
			splo_q   <= src_port_low;
			sphi_q   <= src_port_high;
			dplo_q   <= dst_port_low;
			dphi_q   <= dst_port_high;
			prio_q   <= priority_req;
			target_q <= target_rule_id;
		end
		if (cmd.add_commit) begin
			add_id_q <= next_id_q;
			add_st_q <= prio_bad ? prc_pkg::ST_BAD_PRIO :
				(fill_q == CW'(RULE_SLOTS)) ? prc_pkg::ST_FULL : prc_pkg::ST_OK;
		end
		if (cmd.scan_start)
			mode_q <= cmd.scan_mode;
		idx_s1   <= idx_q[AW-1:0];
		match_s2 <= rd_active && m_proto && m_src && m_dst && m_sp && m_dp;
		idhit_s2 <= (rd_rule.id == target_q);
		act_s2   <= rd_rule.action;
		prio_s2  <= rd_rule.prio;
		id_s2    <= rd_rule.id;
		idx_s2   <= idx_s1;
		if (cmd.result_load) begin
			case (op_q)
				prc_pkg::OP_CLASSIFY: begin
					verdict <= best_v_q && best_act_q;
					hit     <= best_v_q;
					status  <= prc_pkg::ST_OK;
					rule_id <= best_v_q ? best_id_q : '0;
				end
				prc_pkg::OP_DEACT: begin
					verdict <= 1'b0;
					hit     <= 1'b0;
					status  <= found_q ? prc_pkg::ST_OK : prc_pkg::ST_NOT_FOUND;
					rule_id <= target_q;
				end
				default: begin
					verdict <= 1'b0;
					hit     <= 1'b0;
					status  <= add_st_q;
					rule_id <= add_id_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			next_id_q  <= '0;
			scan_on_q  <= 1'b0;
			idx_q      <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			best_v_q   <= 1'b0;
			best_act_q <= 1'b0;
			best_p_q   <= '0;
			best_id_q  <= '0;
			found_q    <= 1'b0;
			low_p_q    <= '0;
			out_valid  <= 1'b0;
		end else begin
			if (cmd.add_commit)
				next_id_q <= next_id_q + 1'b1;
			if (add_ok)
				fill_q <= fill_q + 1'b1;

			// issue one slot read a cycle until the used slots are covered
			if (cmd.scan_start) begin
				scan_on_q <= 1'b1;
				idx_q     <= '0;
				if (cmd.scan_mode != prc_pkg::SM_CLEAR) begin
					best_v_q <= 1'b0;
					found_q  <= 1'b0;
				end
			end else if (scan_on_q) begin
				if ({1'b0, idx_q} + 1'b1 >= {1'b0, fill_q})
					scan_on_q <= 1'b0;
				idx_q <= idx_q + 1'b1;
			end
			v_s1 <= scan_on_q && (idx_q < fill_q);
			v_s2 <= v_s1;

			if (v_s2 && mode_q == prc_pkg::SM_CLASSIFY && match_s2 &&
					(!best_v_q || prio_s2 < best_p_q ||
					(prio_s2 == best_p_q && id_s2 >= best_id_q))) begin
				best_v_q   <= 1'b1;
				best_p_q   <= prio_s2;
				best_id_q  <= id_s2;
				best_act_q <= act_s2;
			end
			if (v_s2 && mode_q == prc_pkg::SM_FIND && idhit_s2) begin
				found_q <= 1'b1;
				if (!found_q || prio_s2 < low_p_q)
					low_p_q <= prio_s2;
			end

			if (cmd.result_load)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

	assign st.op        = op_q;
	assign st.scan_busy = scan_on_q || v_s1 || v_s2;
	assign st.found     = found_q;
	assign st.out_full  = out_valid && out_stall;
endmodule
`default_nettype wire

// ----- src/priority_rule_packet_classifier.sv -----
// Top level of the priority rule packet classifier.
//
// One input channel (in_valid/in_stall) carries a word per command: classify a
// packet, add a pass or block rule, or deactivate a rule by id. One output
// channel (out_valid/out_stall) returns one result word per command, in order.
// Rules fill slots in order and are never freed; at most RULE_SLOTS rules.
// Throughput: one command at a time. An add needs no scan; a classify scans
// the N stored rules once and a deactivate up to twice (find, then clear),
// each scan reading the rule RAM one slot per cycle through its registered
// read port and a two-stage match.
// A new command is taken as soon as the previous one has left the sequencer,
// even while its result still waits in the output register.
// If the receiver stalls with a result held, the next finished result waits
// inside until the register frees. Reset empties the table, clears the id
// counter and drops any pending result; no clearing pass is needed.
`default_nettype none
module priority_rule_packet_classifier #(
	parameter int unsigned RULE_SLOTS      = prc_pkg::DEF_RULE_SLOTS,
	parameter int unsigned PRIORITY_LEVELS = prc_pkg::DEF_PRIORITY_LEVELS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [1:0]                   opcode,
	input  wire logic [1:0]                   protocol,
	input  wire logic [prc_pkg::IP_W-1:0]     src_ip,
	input  wire logic [prc_pkg::LEN_W-1:0]    src_prefix_len,
	input  wire logic [prc_pkg::IP_W-1:0]     dst_ip,
	input  wire logic [prc_pkg::LEN_W-1:0]    dst_prefix_len,
	input  wire logic [prc_pkg::PORT_W-1:0]   src_port_low,
	input  wire logic [prc_pkg::PORT_W-1:0]   src_port_high,
	input  wire logic [prc_pkg::PORT_W-1:0]   dst_port_low,
	input  wire logic [prc_pkg::PORT_W-1:0]   dst_port_high,
	input  wire logic [prc_pkg::PRIO_W-1:0]   priority_req,
	input  wire logic [prc_pkg::ID_W-1:0]     target_rule_id,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              verdict,
	output logic                              hit,
	output logic [1:0]                        status,
	output logic [prc_pkg::ID_W-1:0]          rule_id
);
	prc_pkg::prc_cmd_t  cmd;
	prc_pkg::prc_stat_t st;

	prc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	prc_dp #(
		.RULE_SLOTS      (RULE_SLOTS),
		.PRIORITY_LEVELS (PRIORITY_LEVELS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.opcode         (opcode),
		.protocol       (protocol),
		.src_ip         (src_ip),
		.src_prefix_len (src_prefix_len),
		.dst_ip         (dst_ip),
		.dst_prefix_len (dst_prefix_len),
		.src_port_low   (src_port_low),
		.src_port_high  (src_port_high),
		.dst_port_low   (dst_port_low),
		.dst_port_high  (dst_port_high),
		.priority_req   (priority_req),
		.target_rule_id (target_rule_id),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.verdict        (verdict),
		.hit            (hit),
		.status         (status),
		.rule_id        (rule_id)
	);
endmodule
`default_nettype wire
